@@ sv/sss_pkg.sv @@
// Package for the soft servo setpoint shaper: widths, constants, microcode types and program.
package sss_pkg;

	localparam int ADC_W     = 20;
	localparam int SP_W      = 24;
	localparam int ANG_W     = 25;
	localparam int FB_W      = 19;
	localparam int CMD_W     = 14;
	localparam int GAIN_W    = 24;
	localparam int TICK_W    = 20;
	localparam int CNT_W     = 21;
	localparam int ST_W      = 26;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam int PC_W      = 4;
	localparam int OPA_W     = 29;
	localparam int OPB_W     = 27;
	localparam int PROD_W    = 57;

	localparam logic [23:0]        SLOPE_Q32   = 24'd10613337;
	localparam logic signed [30:0] OFFSET_Q16  = 31'sd1680035;
	localparam logic [26:0]        D2R_Q32     = 27'd74961321;
	localparam logic signed [26:0] HALF_PI_Q16 = 27'sd102944;
	localparam logic [22:0]        NINETY_Q16  = 23'd5898240;
	localparam logic [20:0]        RECIP_45    = 21'd1491309;
	localparam int                 DIV45_SHIFT = 26;
	localparam int                 SCALE_SHIFT = 17;

	localparam logic [GAIN_W-1:0] FIRST_GAIN_RST    = 24'd16777;
	localparam logic [GAIN_W-1:0] SECOND_GAIN_RST   = 24'd50332;
	localparam logic [TICK_W-1:0] STARTUP_TICKS_RST = 20'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_GAIN    = 2'd0,
		CFG_SECOND_GAIN   = 2'd1,
		CFG_STARTUP_TICKS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] first_gain;
		logic [GAIN_W-1:0] second_gain;
		logic [TICK_W-1:0] startup_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		A_ADC    = 3'd0,
		A_AVG    = 3'd1,
		A_ANGLE  = 3'd2,
		A_DIFF1  = 3'd3,
		A_DIFF2  = 3'd4,
		A_VCLAMP = 3'd5,
		A_Y      = 3'd6
	} a_sel_t;

	typedef enum logic [2:0] {
		B_RECIP_S = 3'd0,
		B_SLOPE   = 3'd1,
		B_D2R     = 3'd2,
		B_GAIN1   = 3'd3,
		B_GAIN2   = 3'd4,
		B_MAXC    = 3'd5,
		B_RECIP45 = 3'd6
	} b_sel_t;

	typedef enum logic [3:0] {
		WB_NONE   = 4'd0,
		WB_AVG    = 4'd1,
		WB_ANGLE  = 4'd2,
		WB_FB     = 4'd3,
		WB_TARGET = 4'd4,
		WB_SPEED  = 4'd5,
		WB_VANG   = 4'd6,
		WB_Y      = 4'd7,
		WB_CMD    = 4'd8
	} wb_t;

	typedef enum logic {
		JC_NONE        = 1'b0,
		JC_NOT_STARTED = 1'b1
	} jc_t;

	typedef struct packed {
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		logic            mul_en;
		wb_t             wb;
		jc_t             jc;
		logic [PC_W-1:0] target;
		logic            emit;
	} ucode_t;

	typedef struct packed {
		logic   start;
		logic   step;
		logic   emit;
		ucode_t uc;
	} ctrl_t;

	localparam logic [PC_W-1:0] STEP_EMIT = 4'd14;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{a_sel: A_ADC, b_sel: B_RECIP_S, mul_en: 1'b0, wb: WB_NONE,
			jc: JC_NONE, target: '0, emit: 1'b0};
		case (pc)
			4'd0: begin
				w.a_sel = A_ADC; w.b_sel = B_RECIP_S; w.mul_en = 1'b1;
			end
			4'd1: begin
				w.wb = WB_AVG;
			end
			4'd2: begin
				w.a_sel = A_AVG; w.b_sel = B_SLOPE; w.mul_en = 1'b1;
			end
			4'd3: begin
				w.wb = WB_ANGLE;
			end
			4'd4: begin
				w.a_sel = A_ANGLE; w.b_sel = B_D2R; w.mul_en = 1'b1;
			end
			4'd5: begin
				w.wb = WB_FB; w.a_sel = A_DIFF1; w.b_sel = B_GAIN1; w.mul_en = 1'b1;
				w.jc = JC_NOT_STARTED; w.target = STEP_EMIT;
			end
			4'd6: begin
				w.wb = WB_TARGET;
			end
			4'd7: begin
				w.a_sel = A_DIFF2; w.b_sel = B_GAIN2; w.mul_en = 1'b1;
			end
			4'd8: begin
				w.wb = WB_SPEED;
			end
			4'd9: begin
				w.wb = WB_VANG;
			end
			4'd10: begin
				w.a_sel = A_VCLAMP; w.b_sel = B_MAXC; w.mul_en = 1'b1;
			end
			4'd11: begin
				w.wb = WB_Y;
			end
			4'd12: begin
				w.a_sel = A_Y; w.b_sel = B_RECIP45; w.mul_en = 1'b1;
			end
			4'd13: begin
				w.wb = WB_CMD;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
			end
			default: begin
				w.emit = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

@@ sv/sss_if.sv @@
// Stream interfaces for the input items and the result items of the shaper.
interface sss_in_if;
	import sss_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [ADC_W-1:0]       adc_sum;
	logic signed [SP_W-1:0] angle_setpoint;

	modport source(output valid, output adc_sum, output angle_setpoint, input ready);
	modport sink(input valid, input adc_sum, input angle_setpoint, output ready);
endinterface

interface sss_out_if;
	import sss_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] measured_angle;
	logic signed [FB_W-1:0]  feedback_position;
	logic [CMD_W-1:0]        servo_command;
	logic                    running;

	modport source(output valid, output measured_angle, output feedback_position,
		output servo_command, output running, input ready);
	modport sink(input valid, input measured_angle, input feedback_position,
		input servo_command, input running, output ready);
endinterface

@@ sv/soft_servo_setpoint_shaper_core.sv @@
// Top level of the soft servo setpoint shaper: configuration registers, result register, sequencer.
//
//   Channel  Role   Carries
//   sample   sink   adc_sum, angle_setpoint
//   result   source measured_angle, feedback_position, servo_command, running
//   cfg_*    write  first_gain, second_gain, startup_ticks
//
// An item runs through the microprogram steps, which share one 29 by 28 bit multiplier;
// while start-up is still counting, the steps after the feedback position are skipped.
// The next item is accepted in the cycle its predecessor moves to the result
// register. Reset clears the sequencer, the filter state and the result valid flag, and loads
// the register reset values. A stalled result holds the sequencer in its final step.
module soft_servo_setpoint_shaper_core #(
	parameter int SAMPLES = 16,
	parameter int MAX_CMD = 9600
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sss_in_if.sink                           sample,
	sss_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sss_pkg::CFG_W-1:0]        cfg_data
);
	import sss_pkg::*;

	cfg_t                    cfg_q;
	ctrl_t                   ctrl;
	logic                    started;
	logic                    emit_ok;
	logic signed [ANG_W-1:0] dp_angle;
	logic signed [FB_W-1:0]  dp_fb;
	logic [CMD_W-1:0]        dp_cmd;

	logic                    res_valid_q;
	logic signed [ANG_W-1:0] res_angle_q;
	logic signed [FB_W-1:0]  res_fb_q;
	logic [CMD_W-1:0]        res_cmd_q;
	logic                    res_running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_gain    <= FIRST_GAIN_RST;
			cfg_q.second_gain   <= SECOND_GAIN_RST;
			cfg_q.startup_ticks <= STARTUP_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_GAIN:    cfg_q.first_gain    <= cfg_data;
				CFG_SECOND_GAIN:   cfg_q.second_gain   <= cfg_data;
				CFG_STARTUP_TICKS: cfg_q.startup_ticks <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign emit_ok = !res_valid_q || result.ready;

	sss_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.emit_ok  (emit_ok),
		.started  (started),
		.ready    (sample.ready),
		.ctrl     (ctrl)
	);

	sss_datapath #(
		.SAMPLES (SAMPLES),
		.MAX_CMD (MAX_CMD)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.cfg               (cfg_q),
		.adc_sum           (sample.adc_sum),
		.angle_setpoint    (sample.angle_setpoint),
		.measured_angle    (dp_angle),
		.feedback_position (dp_fb),
		.held_command      (dp_cmd),
		.started           (started)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			res_angle_q   <= dp_angle;
			res_fb_q      <= dp_fb;
			res_cmd_q     <= dp_cmd;
			res_running_q <= started;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.measured_angle    = res_angle_q;
	assign result.feedback_position = res_fb_q;
	assign result.servo_command     = res_cmd_q;
	assign result.running           = res_running_q;

`ifndef SYNTH
	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started))
		else $error("Control stopped running without a reset.");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!res_valid_q || result.ready))
		else $error("Result register overwritten before its item was taken.");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.servo_command <= CMD_W'(MAX_CMD)))
		else $error("Servo command above its maximum.");
`endif

endmodule

@@ sv/sss_useq.sv @@
// Microcode sequencer: step counter, control store fetch, conditional jump and item handshake.
module sss_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           emit_ok,
	input  logic           started,
	output logic           ready,
	output sss_pkg::ctrl_t ctrl
);
	import sss_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            fire;
	logic            start;
	logic            taken;

	always_comb begin
		uc    = ucode_rom(pc_q);
		fire  = busy_q && uc.emit && emit_ok;
		ready = !busy_q || fire;
		start = in_valid && ready;
		taken = (uc.jc == JC_NOT_STARTED) && !started;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (fire) begin
			busy_q <= 1'b0;
		end else if (busy_q && !uc.emit) begin
			pc_q <= taken ? uc.target : pc_q + 1'b1;
		end
	end

	assign ctrl = '{start: start, step: busy_q, emit: fire, uc: uc};

endmodule

@@ sv/sss_datapath.sv @@
// Datapath: shared multiplier, working registers, filter state and start-up counter.
module sss_datapath #(
	parameter int SAMPLES = 16,
	parameter int MAX_CMD = 9600
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sss_pkg::ctrl_t                   ctrl,
	input  sss_pkg::cfg_t                    cfg,
	input  logic [sss_pkg::ADC_W-1:0]        adc_sum,
	input  logic signed [sss_pkg::SP_W-1:0]  angle_setpoint,
	output logic signed [sss_pkg::ANG_W-1:0] measured_angle,
	output logic signed [sss_pkg::FB_W-1:0]  feedback_position,
	output logic [sss_pkg::CMD_W-1:0]        held_command,
	output logic                             started
);
	import sss_pkg::*;

	// Exact floor division by SAMPLES through a rounded-up reciprocal.
	localparam int     KS      = ADC_W + $clog2(SAMPLES);
	localparam longint RECIP_S = ((64'd1 << KS) + SAMPLES - 1) / SAMPLES;

	logic [ADC_W-1:0]        adc_q;
	logic signed [SP_W-1:0]  sp_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    started_q;
	logic [ADC_W-1:0]        avg_q;
	logic signed [ANG_W-1:0] angle_q;
	logic signed [FB_W-1:0]  fb_q;
	logic signed [26:0]      target_q;
	logic signed [ST_W-1:0]  va_q;
	logic signed [ST_W-1:0]  vs_q;
	logic [ADC_W-1:0]        y_q;
	logic [CMD_W-1:0]        held_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [CNT_W-1:0]         cnt_next;
	logic [22:0]              sp_c;
	logic signed [26:0]       diff1;
	logic signed [27:0]       diff2;
	logic                     va_pos;
	logic                     va_full;
	logic [22:0]              vclamp;
	logic signed [OPA_W-1:0]  op_a;
	logic [OPB_W-1:0]         op_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [30:0]       ang_w;
	logic signed [ANG_W-1:0]  ang_c;
	logic signed [26:0]       fb_r;
	logic signed [26:0]       fb_w;
	logic signed [FB_W-1:0]   fb_c;
	logic signed [26:0]       tgt_w;
	logic signed [27:0]       dsp_w;
	logic signed [28:0]       vs_sum;
	logic signed [ST_W-1:0]   vs_c;
	logic signed [26:0]       va_sum;
	logic signed [ST_W-1:0]   va_c;
	logic [CMD_W-1:0]         cmd_w;

	always_comb begin
		cnt_next = cnt_q + 1'b1;

		if (sp_q[SP_W-1]) begin
			sp_c = '0;
		end else if (sp_q > $signed({1'b0, NINETY_Q16})) begin
			sp_c = NINETY_Q16;
		end else begin
			sp_c = sp_q[22:0];
		end

		diff1   = $signed({4'd0, sp_c}) - $signed({va_q[ST_W-1], va_q});
		diff2   = $signed({target_q[26], target_q}) - $signed({{2{vs_q[ST_W-1]}}, vs_q});
		va_pos  = !va_q[ST_W-1] && (va_q != '0);
		va_full = va_pos && (va_q[24:0] >= {2'd0, NINETY_Q16});
		vclamp  = (va_pos && !va_full) ? va_q[22:0] : '0;

		case (ctrl.uc.a_sel)
			A_ADC:    op_a = $signed({9'd0, adc_q});
			A_AVG:    op_a = $signed({9'd0, avg_q});
			A_ANGLE:  op_a = $signed({{4{angle_q[ANG_W-1]}}, angle_q});
			A_DIFF1:  op_a = $signed({{2{diff1[26]}}, diff1});
			A_DIFF2:  op_a = $signed({diff2[27], diff2});
			A_VCLAMP: op_a = $signed({6'd0, vclamp});
			A_Y:      op_a = $signed({9'd0, y_q});
			default:  op_a = '0;
		endcase

		case (ctrl.uc.b_sel)
			B_RECIP_S: op_b = OPB_W'(RECIP_S);
			B_SLOPE:   op_b = {3'd0, SLOPE_Q32};
			B_D2R:     op_b = D2R_Q32;
			B_GAIN1:   op_b = {3'd0, cfg.first_gain};
			B_GAIN2:   op_b = {3'd0, cfg.second_gain};
			B_MAXC:    op_b = OPB_W'(MAX_CMD);
			B_RECIP45: op_b = {6'd0, RECIP_45};
			default:   op_b = '0;
		endcase

		mul_p = op_a * $signed({1'b0, op_b});

		// Rounding half up on a right shift adds the last bit shifted out.
		ang_w = $signed({2'b00, prod_q[44:16]}) + $signed({30'd0, prod_q[15]}) - OFFSET_Q16;
		if (ang_w > 31'sd16777215) begin
			ang_c = 25'sh0FFFFFF;
		end else if (ang_w < -31'sd16777216) begin
			ang_c = 25'sh1000000;
		end else begin
			ang_c = ang_w[ANG_W-1:0];
		end

		fb_r = $signed({{2{prod_q[56]}}, prod_q[56:32]}) + $signed({26'd0, prod_q[31]});
		fb_w = HALF_PI_Q16 - fb_r;
		if (fb_w > 27'sd262143) begin
			fb_c = 19'sh3FFFF;
		end else if (fb_w < -27'sd262144) begin
			fb_c = 19'sh40000;
		end else begin
			fb_c = fb_w[FB_W-1:0];
		end

		tgt_w  = $signed(prod_q[50:24]) + $signed({26'd0, prod_q[23]});
		dsp_w  = $signed(prod_q[51:24]) + $signed({27'd0, prod_q[23]});
		vs_sum = $signed({{3{vs_q[ST_W-1]}}, vs_q}) + $signed({dsp_w[27], dsp_w});
		if (vs_sum > 29'sd33554431) begin
			vs_c = 26'sh1FFFFFF;
		end else if (vs_sum < -29'sd33554432) begin
			vs_c = 26'sh2000000;
		end else begin
			vs_c = vs_sum[ST_W-1:0];
		end

		va_sum = $signed({va_q[ST_W-1], va_q}) + $signed({vs_q[ST_W-1], vs_q});
		if (va_sum > 27'sd33554431) begin
			va_c = 26'sh1FFFFFF;
		end else if (va_sum < -27'sd33554432) begin
			va_c = 26'sh2000000;
		end else begin
			va_c = va_sum[ST_W-1:0];
		end

		if (!va_pos) begin
			cmd_w = '0;
		end else if (va_full) begin
			cmd_w = CMD_W'(MAX_CMD);
		end else begin
			cmd_w = prod_q[DIV45_SHIFT +: CMD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			started_q <= 1'b0;
			va_q      <= '0;
			vs_q      <= '0;
			held_q    <= '0;
		end else begin
			if (ctrl.start && !started_q) begin
				cnt_q <= cnt_next;
				if (cnt_next > {1'b0, cfg.startup_ticks}) begin
					started_q <= 1'b1;
				end
			end
			if (ctrl.step) begin
				case (ctrl.uc.wb)
					WB_SPEED: vs_q   <= vs_c;
					WB_VANG:  va_q   <= va_c;
					WB_CMD:   held_q <= cmd_w;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			adc_q <= adc_sum;
			sp_q  <= angle_setpoint;
		end
		if (ctrl.step && ctrl.uc.mul_en) begin
			prod_q <= mul_p;
		end
		if (ctrl.step) begin
			case (ctrl.uc.wb)
				WB_AVG:    avg_q    <= prod_q[KS +: ADC_W];
				WB_ANGLE:  angle_q  <= ang_c;
				WB_FB:     fb_q     <= fb_c;
				WB_TARGET: target_q <= tgt_w;
				WB_Y:      y_q      <= prod_q[SCALE_SHIFT +: ADC_W];
				default: begin
				end
			endcase
		end
	end

	assign measured_angle    = angle_q;
	assign feedback_position = fb_q;
	assign held_command      = held_q;
	assign started           = started_q;

endmodule
